@@ sv/assert_macros.svh @@
// Assertion macros for the rotation matrix to quaternion RTL.
// Users must have clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property holds at every clock edge outside reset
`define RMQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// condition is never true outside reset
`define RMQ_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`endif

@@ sv/rmq_pkg.sv @@
// Types and constants for the rotation matrix to quaternion pipeline.
// No dependencies.
package rmq_pkg;
	localparam int ENTRY_W       = 16;
	localparam int QUAT_W        = 16;
	localparam int DIFF_W        = 17;
	localparam int QUOT_BITS     = 16;
	localparam int FRAC_BITS_DEF = 14;

	typedef struct packed {
		logic signed [ENTRY_W-1:0] entry_0;
		logic signed [ENTRY_W-1:0] entry_1;
		logic signed [ENTRY_W-1:0] entry_2;
		logic signed [ENTRY_W-1:0] entry_3;
		logic signed [ENTRY_W-1:0] entry_4;
		logic signed [ENTRY_W-1:0] entry_5;
		logic signed [ENTRY_W-1:0] entry_6;
		logic signed [ENTRY_W-1:0] entry_7;
		logic signed [ENTRY_W-1:0] entry_8;
	} matrix_t;

	typedef struct packed {
		logic signed [QUAT_W-1:0] quat_x;
		logic signed [QUAT_W-1:0] quat_y;
		logic signed [QUAT_W-1:0] quat_z;
		logic signed [QUAT_W-1:0] quat_w;
	} quat_t;

	typedef enum logic [1:0] {
		SLOT_X = 2'd0,
		SLOT_Y = 2'd1,
		SLOT_Z = 2'd2,
		SLOT_W = 2'd3
	} slot_t;

	// side data through the root pipe: half slot, lane numerators in slot order
	typedef struct packed {
		slot_t                    half;
		logic signed [DIFF_W-1:0] da;
		logic signed [DIFF_W-1:0] db;
		logic signed [DIFF_W-1:0] dc;
	} sq_side_t;

	// side data through the divider
	typedef struct packed {
		slot_t             half;
		logic [2:0]        neg;
		logic [2:0]        ovf;
		logic              zero;
		logic [QUAT_W-1:0] hv;
	} dv_side_t;
endpackage

@@ sv/rmq_sqrt_pipe.sv @@
// Pipelined integer square root, one root bit per stage.
// Depends on nothing but its parameters.
module rmq_sqrt_pipe #(
	parameter int NW     = 46,
	parameter int SW     = 23,
	parameter int SIDE_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	input  logic [NW-1:0]     rad,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_vld,
	output logic [SW-1:0]     root,
	output logic [SIDE_W-1:0] side_out
);
	localparam int RW = NW + 2;

	logic              vld_s  [SW+1];
	logic [RW-1:0]     rem_s  [SW+1];
	logic [SW-1:0]     root_s [SW+1];
	logic [SIDE_W-1:0] side_s [SW+1];

	assign vld_s[0]  = in_vld;
	assign rem_s[0]  = RW'(rad);
	assign root_s[0] = '0;
	assign side_s[0] = side_in;

	for (genvar g = 0; g < SW; g++) begin : g_stage
		localparam int B = SW - 1 - g;
		logic [RW-1:0] test;
		logic          take;

		// (root + 2^B)^2 - root^2 = root*2^(B+1) + 2^(2B)
		assign test = (RW'(root_s[g]) << (B + 1)) + (RW'(1) << (2 * B));
		assign take = rem_s[g] >= test;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[g+1]  <= take ? rem_s[g] - test : rem_s[g];
			root_s[g+1] <= take ? (root_s[g] | (SW'(1) << B)) : root_s[g];
			side_s[g+1] <= side_s[g];
		end
	end

	assign out_vld  = vld_s[SW];
	assign root     = root_s[SW];
	assign side_out = side_s[SW];
endmodule

@@ sv/rmq_div_pipe.sv @@
// Three-lane restoring divider with a shared divisor, one quotient bit per stage.
// Depends on rmq_pkg for the quotient width.
module rmq_div_pipe #(
	parameter int NUM_W  = 32,
	parameter int DEN_W  = 24,
	parameter int SIDE_W = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_vld,
	input  logic [2:0][NUM_W-1:0]          num,
	input  logic [DEN_W-1:0]               den,
	input  logic [SIDE_W-1:0]              side_in,
	output logic                           out_vld,
	output logic [2:0][rmq_pkg::QUOT_BITS-1:0] quo,
	output logic [SIDE_W-1:0]              side_out
);
	import rmq_pkg::*;

	localparam int CW = ((NUM_W > DEN_W + QUOT_BITS) ? NUM_W : DEN_W + QUOT_BITS) + 1;

	logic                           vld_s  [QUOT_BITS+1];
	logic [2:0][CW-1:0]             rem_s  [QUOT_BITS+1];
	logic [2:0][QUOT_BITS-1:0]      quo_s  [QUOT_BITS+1];
	logic [DEN_W-1:0]               den_s  [QUOT_BITS+1];
	logic [SIDE_W-1:0]              side_s [QUOT_BITS+1];

	assign vld_s[0]  = in_vld;
	assign quo_s[0]  = '0;
	assign den_s[0]  = den;
	assign side_s[0] = side_in;
	for (genvar l = 0; l < 3; l++) begin : g_in
		assign rem_s[0][l] = CW'(num[l]);
	end

	for (genvar g = 0; g < QUOT_BITS; g++) begin : g_stage
		localparam int B = QUOT_BITS - 1 - g;
		logic [CW-1:0] dsh;

		assign dsh = CW'(den_s[g]) << B;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		for (genvar l = 0; l < 3; l++) begin : g_lane
			always_ff @(posedge clk) begin
				if (rem_s[g][l] >= dsh) begin
					rem_s[g+1][l] <= rem_s[g][l] - dsh;
					quo_s[g+1][l] <= quo_s[g][l] | (QUOT_BITS'(1) << B);
				end else begin
					rem_s[g+1][l] <= rem_s[g][l];
					quo_s[g+1][l] <= quo_s[g][l];
				end
			end
		end

		always_ff @(posedge clk) begin
			den_s[g+1]  <= den_s[g];
			side_s[g+1] <= side_s[g];
		end
	end

	assign out_vld  = vld_s[QUOT_BITS];
	assign quo      = quo_s[QUOT_BITS];
	assign side_out = side_s[QUOT_BITS];
endmodule

@@ sv/rotation_matrix_to_quaternion.sv @@
// Rotation matrix to quaternion (Shepperd), fully pipelined.
// Depends on rmq_pkg, rmq_sqrt_pipe, rmq_div_pipe and assert_macros.svh.
//
//  channel  ports                 handshake
//  -------  --------------------  --------------------------------------
//  in       matrix (matrix_t)     word taken when start && !busy
//  out      quat (quat_t)         word valid for one cycle while done
//
// One word enters per cycle; busy stays low. The pipeline holds one decode
// stage, one stage per root bit (SW = root width, 17 at FRAC_BITS = 14), a
// prep stage, one stage per quotient bit and the output register.
// Reset clears only the valid bits. The receiver cannot stall.
`include "assert_macros.svh"
module rotation_matrix_to_quaternion #(
	parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  rmq_pkg::matrix_t matrix,
	output logic             done,
	output rmq_pkg::quat_t   quat
);
	import rmq_pkg::*;

	localparam int TW     = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 3;
	localparam int NW     = TW - 1 + FRAC_BITS;
	localparam int SW     = (NW + 1) / 2;
	localparam int NUMW   = FRAC_BITS + DIFF_W + 1;
	localparam int DENW   = SW + 1;
	localparam int CMPW   = ((NUMW > DENW + QUOT_BITS) ? NUMW : DENW + QUOT_BITS) + 1;
	localparam int LAT    = SW + 3 + QUOT_BITS;
	localparam int SQ_SW  = $bits(sq_side_t);
	localparam int DV_SW  = $bits(dv_side_t);

	assign busy = 1'b0;

	// ---- stage 1: pivot choice, radicand and numerators
	logic signed [TW-1:0]     e [9];
	logic signed [TW-1:0]     trace, diag_i, diag_j, diag_k, rad_t;
	logic signed [DIFF_W-1:0] m [9];
	logic [1:0]               piv;
	sq_side_t                 side_d;

	always_comb begin
		e[0] = TW'(matrix.entry_0); e[1] = TW'(matrix.entry_1);
		e[2] = TW'(matrix.entry_2); e[3] = TW'(matrix.entry_3);
		e[4] = TW'(matrix.entry_4); e[5] = TW'(matrix.entry_5);
		e[6] = TW'(matrix.entry_6); e[7] = TW'(matrix.entry_7);
		e[8] = TW'(matrix.entry_8);
		for (int n = 0; n < 9; n++) begin
			m[n] = DIFF_W'(e[n]);
		end
		trace = e[0] + e[4] + e[8];
		// ties keep the lower axis
		piv = 2'd0;
		if (e[4] > e[0]) piv = 2'd1;
		if (e[8] > ((piv == 2'd1) ? e[4] : e[0])) piv = 2'd2;
		diag_i = e[0]; diag_j = e[4]; diag_k = e[8];
		side_d = '0;
		if (trace > 0) begin
			side_d.half = SLOT_W;
			side_d.da   = m[5] - m[7];
			side_d.db   = m[6] - m[2];
			side_d.dc   = m[1] - m[3];
			rad_t       = trace + (TW'(1) << FRAC_BITS);
		end else begin
			case (piv)
				2'd0: begin
					side_d.half = SLOT_X;
					side_d.da = m[1] + m[3]; side_d.db = m[2] + m[6]; side_d.dc = m[5] - m[7];
					diag_i = e[0]; diag_j = e[4]; diag_k = e[8];
				end
				2'd1: begin
					side_d.half = SLOT_Y;
					side_d.da = m[1] + m[3]; side_d.db = m[5] + m[7]; side_d.dc = m[6] - m[2];
					diag_i = e[4]; diag_j = e[8]; diag_k = e[0];
				end
				default: begin
					side_d.half = SLOT_Z;
					side_d.da = m[2] + m[6]; side_d.db = m[5] + m[7]; side_d.dc = m[1] - m[3];
					diag_i = e[8]; diag_j = e[0]; diag_k = e[4];
				end
			endcase
			rad_t = diag_i - diag_j - diag_k + (TW'(1) << FRAC_BITS);
		end
	end

	logic          vld_s1;
	logic [NW-1:0] rad_s1;
	sq_side_t      side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		// negative radicand counts as zero
		rad_s1  <= (rad_t > 0) ? {rad_t[TW-2:0], {FRAC_BITS{1'b0}}} : '0;
		side_s1 <= side_d;
	end

	// ---- square root
	logic            sq_vld;
	logic [SW-1:0]   sq_root;
	logic [SQ_SW-1:0] sq_side_bits;
	sq_side_t        sq_side;

	rmq_sqrt_pipe #(.NW(NW), .SW(SW), .SIDE_W(SQ_SW)) u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_s1),
		.rad     (rad_s1),
		.side_in (side_s1),
		.out_vld (sq_vld),
		.root    (sq_root),
		.side_out(sq_side_bits)
	);
	assign sq_side = sq_side_t'(sq_side_bits);

	// ---- stage 2: dividend/divisor prep, overflow check, half part
	logic signed [DIFF_W-1:0] dl [3];
	logic [2:0][NUMW-1:0]     num_d;
	logic [DENW-1:0]          den_d;
	logic [SW:0]              half_sum;
	dv_side_t                 dside_d;

	always_comb begin
		dl[0] = sq_side.da; dl[1] = sq_side.db; dl[2] = sq_side.dc;
		den_d = {sq_root, 1'b0};
		dside_d.half = sq_side.half;
		dside_d.zero = (sq_root == '0);
		for (int l = 0; l < 3; l++) begin
			dside_d.neg[l] = dl[l][DIFF_W-1];
			// round half away: q = (|d|*2^F + S) / (2S)
			num_d[l] = (NUMW'(dl[l][DIFF_W-1] ? -dl[l] : dl[l]) << FRAC_BITS)
			         + NUMW'(sq_root);
			dside_d.ovf[l] = CMPW'(num_d[l]) >= (CMPW'(den_d) << QUOT_BITS);
		end
		half_sum = ((SW+1)'(sq_root) + (SW+1)'(1)) >> 1;
		dside_d.hv = (half_sum > (SW+1)'(32767)) ? QUAT_W'(32767) : QUAT_W'(half_sum);
	end

	logic                 vld_s2;
	logic [2:0][NUMW-1:0] num_s2;
	logic [DENW-1:0]      den_s2;
	dv_side_t             dside_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= sq_vld;
		end
	end

	always_ff @(posedge clk) begin
		num_s2   <= num_d;
		den_s2   <= den_d;
		dside_s2 <= dside_d;
	end

	// ---- divider
	logic                      dv_vld;
	logic [2:0][QUOT_BITS-1:0] dv_quo;
	logic [DV_SW-1:0]          dv_side_bits;
	dv_side_t                  dv_side;

	rmq_div_pipe #(.NUM_W(NUMW), .DEN_W(DENW), .SIDE_W(DV_SW)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_s2),
		.num     (num_s2),
		.den     (den_s2),
		.side_in (dside_s2),
		.out_vld (dv_vld),
		.quo     (dv_quo),
		.side_out(dv_side_bits)
	);
	assign dv_side = dv_side_t'(dv_side_bits);

	// ---- stage 3: sign, saturation, slot placement
	logic signed [QUAT_W-1:0] lane [3];
	quat_t                    quat_d;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			if (dv_side.zero) begin
				lane[l] = '0;
			end else if (dv_side.neg[l]) begin
				lane[l] = (dv_side.ovf[l] || dv_quo[l] > QUOT_BITS'(32768))
				        ? QUAT_W'(16'h8000) : QUAT_W'(-dv_quo[l]);
			end else begin
				lane[l] = (dv_side.ovf[l] || dv_quo[l] > QUOT_BITS'(32767))
				        ? QUAT_W'(16'h7fff) : QUAT_W'(dv_quo[l]);
			end
		end
		case (dv_side.half)
			SLOT_X: quat_d = {dv_side.hv, lane[0], lane[1], lane[2]};
			SLOT_Y: quat_d = {lane[0], dv_side.hv, lane[1], lane[2]};
			SLOT_Z: quat_d = {lane[0], lane[1], dv_side.hv, lane[2]};
			default: quat_d = {lane[0], lane[1], lane[2], dv_side.hv};
		endcase
	end

	logic  done_s3;
	quat_t quat_s3;
	logic  zero_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s3 <= 1'b0;
		end else begin
			done_s3 <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		quat_s3 <= quat_d;
		zero_s3 <= dv_side.zero;
	end

	assign done = done_s3;
	assign quat = quat_s3;

	`RMQ_NEVER(a_busy_low, busy, "busy raised on a stall-free pipeline")
	`RMQ_ASSERT(a_latency, (start && !busy) |-> ##LAT done, "accepted word not delivered")
	`RMQ_ASSERT(a_zero_root, (done && zero_s3) |-> (quat == '0), "zero root gave nonzero parts")
endmodule
